// ===== rtl/tvx_pkg.sv =====
// ----------------------------------------------------------------------------
// tvx_pkg
// Shared types and constants of the two-arm reaction vertex block.
// ----------------------------------------------------------------------------
package tvx_pkg;

    localparam int POS_W      = 24;
    localparam int DIST_W     = 24;
    localparam int SIGMA_W    = 23;
    localparam int TRIG_W     = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DISTANCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_COS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SIN      = 3'd5;

    localparam logic signed [TRIG_W-1:0] COS_RESET = 18'sd65536;

    localparam int NUM_W     = 57;
    localparam int CR_W      = 32;
    localparam int DG_W      = 47;
    localparam int DIV_NUM_W = 63;
    localparam int DIV_DEN_W = 32;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                    tracks_present;
        logic signed [POS_W-1:0] left_position;
        logic signed [POS_W-1:0] left_slope;
        logic [SIGMA_W-1:0]      left_slope_sigma;
        logic signed [POS_W-1:0] right_position;
        logic signed [POS_W-1:0] right_slope;
        logic [SIGMA_W-1:0]      right_slope_sigma;
        logic signed [POS_W-1:0] beam_x;
        logic signed [POS_W-1:0] beam_y;
        logic signed [POS_W-1:0] beam_slope_x;
        logic signed [POS_W-1:0] beam_slope_y;
    } tvx_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] vertex_x;
        logic signed [POS_W-1:0] vertex_y;
        logic signed [POS_W-1:0] vertex_z;
        logic signed [POS_W-1:0] angle_x;
        logic signed [POS_W-1:0] angle_y;
        logic                    status;
    } tvx_result_t;

    typedef struct packed {
        logic [DIST_W-1:0]        left_distance;
        logic [DIST_W-1:0]        right_distance;
        logic signed [TRIG_W-1:0] left_cos;
        logic signed [TRIG_W-1:0] left_sin;
        logic signed [TRIG_W-1:0] right_cos;
        logic signed [TRIG_W-1:0] right_sin;
    } tvx_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] slope_x;
        logic signed [POS_W-1:0] slope_y;
    } tvx_beam_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic signed [CR_W-1:0]  cr;
        logic [DG_W-1:0]         dg;
    } tvx_arm_t;

    typedef struct packed {
        tvx_arm_t  arm_l;
        tvx_arm_t  arm_r;
        tvx_beam_t beam;
    } tvx_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tvx_queue_stat_t;

endpackage

// ===== rtl/two_arm_reaction_vertex.sv =====
// ----------------------------------------------------------------------------
// two_arm_reaction_vertex
// Reaction vertex from a left and a right recoil track and a beam track.
// ----------------------------------------------------------------------------
// Takes one event transaction per clock and gives one result per clock once
// full, while result_ready is held high; events without all three tracks give
// no result. The path holds 141 register stages: four geometry stages in the
// front, the queue, then two bit-per-stage divider pipelines of 63 stages each
// (arm z and error, then the weighted z) with ten more stages around them. The
// first stage loads on the accepting edge. Stalls on the result side reach the
// front only when the four-entry queue between the two halves is full. The user
// must write arm registers through the configuration port only while no event
// is in flight; the block itself does not enforce this.
module two_arm_reaction_vertex (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  tvx_pkg::tvx_item_t                item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output tvx_pkg::tvx_result_t              result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tvx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tvx_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tvx_pkg::*;

    tvx_cfg_t        cfg_reg;
    tvx_job_t        push_job;
    tvx_job_t        pop_job;
    logic            q_push;
    logic            q_pop;
    tvx_queue_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_distance  <= '0;
            cfg_reg.right_distance <= '0;
            cfg_reg.left_cos       <= COS_RESET;
            cfg_reg.left_sin       <= '0;
            cfg_reg.right_cos      <= COS_RESET;
            cfg_reg.right_sin      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEFT_DISTANCE:  cfg_reg.left_distance  <= cfg_data;
                REG_RIGHT_DISTANCE: cfg_reg.right_distance <= cfg_data;
                REG_LEFT_COS:       cfg_reg.left_cos       <= $signed(cfg_data[TRIG_W-1:0]);
                REG_LEFT_SIN:       cfg_reg.left_sin       <= $signed(cfg_data[TRIG_W-1:0]);
                REG_RIGHT_COS:      cfg_reg.right_cos      <= $signed(cfg_data[TRIG_W-1:0]);
                REG_RIGHT_SIN:      cfg_reg.right_sin      <= $signed(cfg_data[TRIG_W-1:0]);
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    tvx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_stat     (q_stat),
        .push       (q_push),
        .job        (push_job)
    );

    tvx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .pop       (q_pop),
        .pop_data  (pop_job),
        .stat      (q_stat)
    );

    tvx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_data       (pop_job),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // failed vertex carries zero positions
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |->
            result.vertex_x == '0 && result.vertex_y == '0 && result.vertex_z == '0)
        else $error("vertex not zeroed on bad status");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

endmodule

// ===== rtl/tvx_div.sv =====
// ----------------------------------------------------------------------------
// tvx_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module tvx_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [tvx_pkg::DIV_NUM_W-1:0]  num,
    input  logic [tvx_pkg::DIV_DEN_W-1:0]  den,
    output logic [tvx_pkg::DIV_NUM_W-1:0]  quo
);
    import tvx_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg  [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] rem_next [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] acc_reg  [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] acc_next [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] rem_src  [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] acc_src  [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] den_src  [DIV_NUM_W];
    logic [DIV_DEN_W:0]   trial    [DIV_NUM_W];

    always_comb
    begin
        rem_src[0] = '0;
        acc_src[0] = num;
        den_src[0] = den;
        for (int s = 1; s < DIV_NUM_W; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            acc_src[s] = acc_reg[s-1];
            den_src[s] = den_reg[s-1];
        end
        for (int s = 0; s < DIV_NUM_W; s++)
        begin
            trial[s] = {rem_src[s], acc_src[s][DIV_NUM_W-1]};
            if (trial[s] >= {1'b0, den_src[s]})
            begin
                rem_next[s] = DIV_DEN_W'(trial[s] - {1'b0, den_src[s]});
                acc_next[s] = {acc_src[s][DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = trial[s][DIV_DEN_W-1:0];
                acc_next[s] = {acc_src[s][DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_NUM_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                acc_reg[s] <= acc_next[s];
                den_reg[s] <= den_src[s];
            end
        end
    end

    assign quo = acc_reg[DIV_NUM_W-1];

endmodule

// ===== rtl/tvx_front.sv =====
// ----------------------------------------------------------------------------
// tvx_front
// Accepts event transactions, drops incomplete ones and works out the arm
// geometry: rotated tracks, crossing numerator and divisor per arm.
// ----------------------------------------------------------------------------
module tvx_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tvx_pkg::tvx_cfg_t        cfg,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  tvx_pkg::tvx_item_t       item,
    input  tvx_pkg::tvx_queue_stat_t q_stat,
    output logic                     push,
    output tvx_pkg::tvx_job_t        job
);
    import tvx_pkg::*;

    logic adv;

    logic [DIST_W-1:0]        dist_v [2];
    logic signed [TRIG_W-1:0] cosv [2];
    logic signed [TRIG_W-1:0] sinv [2];
    logic signed [POS_W-1:0]  pos  [2];
    logic signed [POS_W-1:0]  slp  [2];
    logic [SIGMA_W-1:0]       sig  [2];

    // stage 1: products
    logic signed [41:0] as_next [2], as_reg [2];
    logic signed [41:0] ac_next [2], ac_reg [2];
    logic signed [42:0] dc_next [2], dc_reg [2];
    logic signed [41:0] xs_next [2], xs_reg [2];
    logic signed [42:0] ds_next [2], ds_reg [2];
    logic signed [41:0] xc_next [2], xc_reg [2];
    logic [DG_W-1:0]    dg1_next [2], dg1_reg [2];
    tvx_beam_t          beam1_reg;
    logic               f1_valid_reg;

    // stage 2: rotated direction and point
    logic signed [42:0] pxt [2];
    logic signed [42:0] pyt [2];
    logic signed [43:0] rxt [2];
    logic signed [43:0] ryt [2];
    logic signed [26:0] px_next [2], px_reg [2];
    logic signed [26:0] py_next [2], py_reg [2];
    logic signed [27:0] rx_next [2], rx_reg [2];
    logic signed [28:0] ry_next [2], ry_reg [2];
    logic [DG_W-1:0]    dg2_reg [2];
    tvx_beam_t          beam2_reg;
    logic               f2_valid_reg;

    // stage 3: cross products
    logic signed [55:0] pr_next [2], pr_reg [2];
    logic signed [54:0] qr_next [2], qr_reg [2];
    logic signed [50:0] pa_next [2], pa_reg [2];
    logic signed [26:0] py3_reg [2];
    logic [DG_W-1:0]    dg3_reg [2];
    tvx_beam_t          beam3_reg;
    logic               f3_valid_reg;

    // stage 4: numerator and divisor
    logic signed [52:0]     crt [2];
    logic signed [NUM_W-1:0] num_next [2], num_reg [2];
    logic signed [CR_W-1:0]  cr_next [2], cr_reg [2];
    logic [DG_W-1:0]         dg4_reg [2];
    tvx_beam_t               beam4_reg;
    logic                    f4_valid_reg;

    tvx_beam_t beam_in;

    assign adv        = !f4_valid_reg || !q_stat.full;
    assign item_ready = adv;
    assign push       = f4_valid_reg && !q_stat.full;

    assign dist_v[0] = cfg.left_distance;
    assign dist_v[1] = cfg.right_distance;
    assign cosv[0] = cfg.left_cos;
    assign cosv[1] = cfg.right_cos;
    assign sinv[0] = cfg.left_sin;
    assign sinv[1] = cfg.right_sin;
    assign pos[0]  = item.left_position;
    assign pos[1]  = item.right_position;
    assign slp[0]  = item.left_slope;
    assign slp[1]  = item.right_slope;
    assign sig[0]  = item.left_slope_sigma;
    assign sig[1]  = item.right_slope_sigma;

    assign beam_in.x       = item.beam_x;
    assign beam_in.y       = item.beam_y;
    assign beam_in.slope_x = item.beam_slope_x;
    assign beam_in.slope_y = item.beam_slope_y;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            as_next[i]  = slp[i] * sinv[i];
            ac_next[i]  = slp[i] * cosv[i];
            dc_next[i]  = $signed({1'b0, dist_v[i]}) * cosv[i];
            xs_next[i]  = pos[i] * sinv[i];
            ds_next[i]  = $signed({1'b0, dist_v[i]}) * sinv[i];
            xc_next[i]  = pos[i] * cosv[i];
            dg1_next[i] = dist_v[i] * sig[i];

            pxt[i]     = $signed({cosv[i], 20'd0}) - as_reg[i];
            pyt[i]     = $signed({sinv[i], 20'd0}) + ac_reg[i];
            rxt[i]     = dc_reg[i] - xs_reg[i];
            ryt[i]     = ds_reg[i] + xc_reg[i];
            px_next[i] = pxt[i][42:16];
            py_next[i] = pyt[i][42:16];
            rx_next[i] = rxt[i][43:16];
            ry_next[i] = $signed(ryt[i][43:16]) + beam1_reg.x;

            pr_next[i] = px_reg[i] * ry_reg[i];
            qr_next[i] = py_reg[i] * rx_reg[i];
            pa_next[i] = px_reg[i] * beam2_reg.slope_x;

            num_next[i] = pr_reg[i] - qr_reg[i];
            crt[i]      = -pa_reg[i] - $signed({py3_reg[i], 20'd0});
            cr_next[i]  = crt[i][51:20];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= item_valid && item.tracks_present;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 2; i++)
            begin
                as_reg[i]  <= as_next[i];
                ac_reg[i]  <= ac_next[i];
                dc_reg[i]  <= dc_next[i];
                xs_reg[i]  <= xs_next[i];
                ds_reg[i]  <= ds_next[i];
                xc_reg[i]  <= xc_next[i];
                dg1_reg[i] <= dg1_next[i];
                px_reg[i]  <= px_next[i];
                py_reg[i]  <= py_next[i];
                rx_reg[i]  <= rx_next[i];
                ry_reg[i]  <= ry_next[i];
                dg2_reg[i] <= dg1_reg[i];
                pr_reg[i]  <= pr_next[i];
                qr_reg[i]  <= qr_next[i];
                pa_reg[i]  <= pa_next[i];
                py3_reg[i] <= py_reg[i];
                dg3_reg[i] <= dg2_reg[i];
                num_reg[i] <= num_next[i];
                cr_reg[i]  <= cr_next[i];
                dg4_reg[i] <= dg3_reg[i];
            end
            beam1_reg <= beam_in;
            beam2_reg <= beam1_reg;
            beam3_reg <= beam2_reg;
            beam4_reg <= beam3_reg;
        end
    end

    assign job.arm_l.num = num_reg[0];
    assign job.arm_l.cr  = cr_reg[0];
    assign job.arm_l.dg  = dg4_reg[0];
    assign job.arm_r.num = num_reg[1];
    assign job.arm_r.cr  = cr_reg[1];
    assign job.arm_r.dg  = dg4_reg[1];
    assign job.beam      = beam4_reg;

endmodule

// ===== rtl/tvx_fifo.sv =====
// ----------------------------------------------------------------------------
// tvx_fifo
// Short queue of geometry results between the front and the back.
// ----------------------------------------------------------------------------
module tvx_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  tvx_pkg::tvx_job_t        push_data,
    input  logic                     pop,
    output tvx_pkg::tvx_job_t        pop_data,
    output tvx_pkg::tvx_queue_stat_t stat
);
    import tvx_pkg::*;

    tvx_job_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign stat.full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/tvx_back.sv =====
// ----------------------------------------------------------------------------
// tvx_back
// Divides per arm, weights the two z values, divides again and projects
// the vertex onto the beam; ends in the result register.
// ----------------------------------------------------------------------------
module tvx_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tvx_pkg::tvx_queue_stat_t q_stat,
    input  tvx_pkg::tvx_job_t        q_data,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output tvx_pkg::tvx_result_t     result
);
    import tvx_pkg::*;

    typedef struct packed {
        logic      zneg_l;
        logic      zneg_r;
        logic      ok;
        tvx_beam_t beam;
    } tvx_side1_t;

    typedef struct packed {
        logic      neg;
        logic      ok;
        tvx_beam_t beam;
    } tvx_side2_t;

    function automatic logic signed [31:0] clamp_z(input logic [DIV_NUM_W-1:0] q,
                                                   input logic neg);
        logic signed [31:0] r;
        if (neg)
        begin
            if (q > 63'd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = $signed(~q[31:0] + 32'd1);
            end
        end
        else
        begin
            if (q > 63'd2147483647)
            begin
                r = 32'sh7fffffff;
            end
            else
            begin
                r = $signed(q[31:0]);
            end
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [28:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 29'sd8388607)
        begin
            r = 24'sh7fffff;
        end
        else if (v < -29'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    logic adv;

    // stage 0
    logic     b0_valid_reg;
    tvx_job_t b0_job_reg;

    logic [NUM_W-1:0]     zmag_l, zmag_r;
    logic [DIV_DEN_W-1:0] crmag_l, crmag_r;
    logic [DIV_NUM_W-1:0] q_zl, q_zr, q_dl, q_dr;
    tvx_side1_t           side1_in;
    tvx_side1_t           side1_reg [DIV_NUM_W];
    logic                 dv1_reg   [DIV_NUM_W];

    // stage 1
    logic               b1_valid_reg;
    logic signed [31:0] b1_zl_reg, b1_zr_reg;
    logic [DG_W-1:0]    b1_dl_reg, b1_dr_reg, b1_m_reg;
    logic               b1_ok_reg;
    tvx_beam_t          b1_beam_reg;

    // stage 2
    logic [5:0]         k_next;
    logic               b2_valid_reg;
    logic [5:0]         b2_k_reg;
    logic signed [31:0] b2_zl_reg, b2_zr_reg;
    logic [DG_W-1:0]    b2_dl_reg, b2_dr_reg;
    logic               b2_ok_reg;
    tvx_beam_t          b2_beam_reg;

    // stage 3
    logic               b3_valid_reg;
    logic [14:0]        b3_sl_reg, b3_sr_reg;
    logic signed [31:0] b3_zl_reg, b3_zr_reg;
    logic               b3_ok_reg;
    tvx_beam_t          b3_beam_reg;

    // stage 4
    logic               b4_valid_reg;
    logic [29:0]        b4_wl_reg, b4_wr_reg;
    logic signed [31:0] b4_zl_reg, b4_zr_reg;
    logic               b4_ok_reg;
    tvx_beam_t          b4_beam_reg;

    // stage 5
    logic signed [62:0] pl_next, pr_next;
    logic               b5_valid_reg;
    logic signed [62:0] b5_pl_reg, b5_pr_reg;
    logic [30:0]        b5_wsum_reg;
    logic               b5_ok_reg;
    tvx_beam_t          b5_beam_reg;

    // stage 6
    logic               b6_valid_reg;
    logic signed [62:0] b6_numf_reg;
    logic [30:0]        b6_wsum_reg;
    logic               b6_ok_reg;
    tvx_beam_t          b6_beam_reg;

    logic [DIV_NUM_W-1:0] nmag;
    logic [DIV_NUM_W-1:0] q_vz;
    tvx_side2_t           side2_in;
    tvx_side2_t           side2_reg [DIV_NUM_W];
    logic                 dv2_reg   [DIV_NUM_W];

    // stage 7
    logic signed [POS_W-1:0] vz_next;
    logic                    b7_valid_reg;
    logic signed [POS_W-1:0] b7_vz_reg;
    logic                    b7_ok_reg;
    tvx_beam_t               b7_beam_reg;

    // stage 8
    logic                    b8_valid_reg;
    logic signed [47:0]      b8_mx_reg, b8_my_reg;
    logic signed [POS_W-1:0] b8_vz_reg;
    logic                    b8_ok_reg;
    tvx_beam_t               b8_beam_reg;

    // result
    logic signed [28:0] vx_t, vy_t, ax_t;
    tvx_result_t        result_next;
    logic               result_valid_reg;
    tvx_result_t        result_reg;

    assign adv          = !result_valid_reg || result_ready;
    assign pop          = adv && !q_stat.empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // magnitudes for the arm dividers
    assign zmag_l  = b0_job_reg.arm_l.num[NUM_W-1] ? ~b0_job_reg.arm_l.num + 1'b1
                                                   : b0_job_reg.arm_l.num;
    assign zmag_r  = b0_job_reg.arm_r.num[NUM_W-1] ? ~b0_job_reg.arm_r.num + 1'b1
                                                   : b0_job_reg.arm_r.num;
    assign crmag_l = b0_job_reg.arm_l.cr[CR_W-1] ? ~b0_job_reg.arm_l.cr + 1'b1
                                                 : b0_job_reg.arm_l.cr;
    assign crmag_r = b0_job_reg.arm_r.cr[CR_W-1] ? ~b0_job_reg.arm_r.cr + 1'b1
                                                 : b0_job_reg.arm_r.cr;

    assign side1_in.zneg_l = b0_job_reg.arm_l.num[NUM_W-1] ^ b0_job_reg.arm_l.cr[CR_W-1];
    assign side1_in.zneg_r = b0_job_reg.arm_r.num[NUM_W-1] ^ b0_job_reg.arm_r.cr[CR_W-1];
    assign side1_in.ok     = (b0_job_reg.arm_l.cr != '0) && (b0_job_reg.arm_r.cr != '0);
    assign side1_in.beam   = b0_job_reg.beam;

    tvx_div u_div_zl (
        .clk (clk),
        .en  (adv),
        .num ({{(DIV_NUM_W-NUM_W){1'b0}}, zmag_l}),
        .den (crmag_l),
        .quo (q_zl)
    );

    tvx_div u_div_zr (
        .clk (clk),
        .en  (adv),
        .num ({{(DIV_NUM_W-NUM_W){1'b0}}, zmag_r}),
        .den (crmag_r),
        .quo (q_zr)
    );

    tvx_div u_div_dl (
        .clk (clk),
        .en  (adv),
        .num ({{(DIV_NUM_W-DG_W){1'b0}}, b0_job_reg.arm_l.dg}),
        .den (crmag_l),
        .quo (q_dl)
    );

    tvx_div u_div_dr (
        .clk (clk),
        .en  (adv),
        .num ({{(DIV_NUM_W-DG_W){1'b0}}, b0_job_reg.arm_r.dg}),
        .den (crmag_r),
        .quo (q_dr)
    );

    // shift that brings the larger error below 2^15
    always_comb
    begin
        k_next = '0;
        for (int i = 15; i < DG_W; i++)
        begin
            if (b1_m_reg[i])
            begin
                k_next = 6'(i - 14);
            end
        end
    end

    assign pl_next = b4_zl_reg * $signed({1'b0, b4_wr_reg});
    assign pr_next = b4_zr_reg * $signed({1'b0, b4_wl_reg});

    assign nmag = b6_numf_reg[62] ? ~b6_numf_reg + 1'b1 : b6_numf_reg;

    assign side2_in.neg  = b6_numf_reg[62];
    assign side2_in.ok   = b6_ok_reg;
    assign side2_in.beam = b6_beam_reg;

    tvx_div u_div_vz (
        .clk (clk),
        .en  (adv),
        .num (nmag),
        .den ({1'b0, b6_wsum_reg}),
        .quo (q_vz)
    );

    always_comb
    begin
        if (!side2_reg[DIV_NUM_W-1].ok)
        begin
            vz_next = '0;
        end
        else if (side2_reg[DIV_NUM_W-1].neg)
        begin
            if (q_vz > 63'd8388608)
            begin
                vz_next = 24'sh800000;
            end
            else
            begin
                vz_next = $signed(~q_vz[POS_W-1:0] + 24'd1);
            end
        end
        else
        begin
            if (q_vz > 63'd8388607)
            begin
                vz_next = 24'sh7fffff;
            end
            else
            begin
                vz_next = $signed(q_vz[POS_W-1:0]);
            end
        end
    end

    always_comb
    begin
        vx_t = -b8_beam_reg.x - $signed(b8_mx_reg[47:20]);
        vy_t = b8_beam_reg.y + $signed(b8_my_reg[47:20]);
        ax_t = -b8_beam_reg.slope_x;
        result_next.vertex_x = b8_ok_reg ? sat24(vx_t) : '0;
        result_next.vertex_y = b8_ok_reg ? sat24(vy_t) : '0;
        result_next.vertex_z = b8_vz_reg;
        result_next.angle_x  = sat24(ax_t);
        result_next.angle_y  = b8_beam_reg.slope_y;
        result_next.status   = !b8_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg     <= 1'b0;
            b1_valid_reg     <= 1'b0;
            b2_valid_reg     <= 1'b0;
            b3_valid_reg     <= 1'b0;
            b4_valid_reg     <= 1'b0;
            b5_valid_reg     <= 1'b0;
            b6_valid_reg     <= 1'b0;
            b7_valid_reg     <= 1'b0;
            b8_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_NUM_W; s++)
            begin
                dv1_reg[s] <= 1'b0;
                dv2_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            b0_valid_reg <= !q_stat.empty;
            dv1_reg[0]   <= b0_valid_reg;
            dv2_reg[0]   <= b6_valid_reg;
            for (int s = 1; s < DIV_NUM_W; s++)
            begin
                dv1_reg[s] <= dv1_reg[s-1];
                dv2_reg[s] <= dv2_reg[s-1];
            end
            b1_valid_reg     <= dv1_reg[DIV_NUM_W-1];
            b2_valid_reg     <= b1_valid_reg;
            b3_valid_reg     <= b2_valid_reg;
            b4_valid_reg     <= b3_valid_reg;
            b5_valid_reg     <= b4_valid_reg;
            b6_valid_reg     <= b5_valid_reg;
            b7_valid_reg     <= dv2_reg[DIV_NUM_W-1];
            b8_valid_reg     <= b7_valid_reg;
            result_valid_reg <= b8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_job_reg   <= q_data;
            side1_reg[0] <= side1_in;
            side2_reg[0] <= side2_in;
            for (int s = 1; s < DIV_NUM_W; s++)
            begin
                side1_reg[s] <= side1_reg[s-1];
                side2_reg[s] <= side2_reg[s-1];
            end

            b1_zl_reg   <= clamp_z(q_zl, side1_reg[DIV_NUM_W-1].zneg_l);
            b1_zr_reg   <= clamp_z(q_zr, side1_reg[DIV_NUM_W-1].zneg_r);
            b1_dl_reg   <= q_dl[DG_W-1:0];
            b1_dr_reg   <= q_dr[DG_W-1:0];
            b1_m_reg    <= (q_dl[DG_W-1:0] > q_dr[DG_W-1:0]) ? q_dl[DG_W-1:0]
                                                             : q_dr[DG_W-1:0];
            b1_ok_reg   <= side1_reg[DIV_NUM_W-1].ok;
            b1_beam_reg <= side1_reg[DIV_NUM_W-1].beam;

            b2_k_reg    <= k_next;
            b2_zl_reg   <= b1_zl_reg;
            b2_zr_reg   <= b1_zr_reg;
            b2_dl_reg   <= b1_dl_reg;
            b2_dr_reg   <= b1_dr_reg;
            b2_ok_reg   <= b1_ok_reg;
            b2_beam_reg <= b1_beam_reg;

            b3_sl_reg   <= 15'(b2_dl_reg >> b2_k_reg);
            b3_sr_reg   <= 15'(b2_dr_reg >> b2_k_reg);
            b3_zl_reg   <= b2_zl_reg;
            b3_zr_reg   <= b2_zr_reg;
            b3_ok_reg   <= b2_ok_reg;
            b3_beam_reg <= b2_beam_reg;

            b4_wl_reg   <= b3_sl_reg * b3_sl_reg;
            b4_wr_reg   <= b3_sr_reg * b3_sr_reg;
            b4_zl_reg   <= b3_zl_reg;
            b4_zr_reg   <= b3_zr_reg;
            b4_ok_reg   <= b3_ok_reg;
            b4_beam_reg <= b3_beam_reg;

            b5_pl_reg   <= pl_next;
            b5_pr_reg   <= pr_next;
            b5_wsum_reg <= {1'b0, b4_wl_reg} + {1'b0, b4_wr_reg};
            b5_ok_reg   <= b4_ok_reg;
            b5_beam_reg <= b4_beam_reg;

            b6_numf_reg <= b5_pl_reg + b5_pr_reg;
            b6_wsum_reg <= b5_wsum_reg;
            b6_ok_reg   <= b5_ok_reg && (b5_wsum_reg != '0);
            b6_beam_reg <= b5_beam_reg;

            b7_vz_reg   <= vz_next;
            b7_ok_reg   <= side2_reg[DIV_NUM_W-1].ok;
            b7_beam_reg <= side2_reg[DIV_NUM_W-1].beam;

            b8_mx_reg   <= b7_vz_reg * b7_beam_reg.slope_x;
            b8_my_reg   <= b7_vz_reg * b7_beam_reg.slope_y;
            b8_vz_reg   <= b7_vz_reg;
            b8_ok_reg   <= b7_ok_reg;
            b8_beam_reg <= b7_beam_reg;

            result_reg  <= result_next;
        end
    end

endmodule

// ===== dv/tb_two_arm_reaction_vertex.sv =====
// ----------------------------------------------------------------------------
// tb_two_arm_reaction_vertex
// Self-checking testbench of the two-arm reaction vertex block: a local
// fixed-point vertex predictor, directed and random events, random idling on
// both channels, a long result hold-off and arm register changes between phases.
// ----------------------------------------------------------------------------
module tb_two_arm_reaction_vertex;
    import tvx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 200;
    localparam int WDOG_MAX  = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    tvx_item_t   item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    tvx_result_t result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tvx_result_t vertex_q[$];
    tvx_item_t   send_q[$];
    tvx_cfg_t    arm_cfg;
    int          errors = 0;
    int          n_events = 0;
    int          n_vertices = 0;
    int          n_status = 0;
    int          quiet_cycles = 0;
    int          idle_pct = 24;
    bit          hold_off = 1'b0;

    always #4 clk = ~clk;

    two_arm_reaction_vertex i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint sat24(longint v);
        if (v < -64'sd8388608)
            return -64'sd8388608;
        if (v > 64'sd8388607)
            return 64'sd8388607;
        return v;
    endfunction

    function automatic bit arm_cross(longint d, longint c, longint s, longint x,
                                     longint a, longint g, longint x0, longint a0,
                                     output longint z, output longint dz);
        longint px, py, rx, ry, num, cr, mag;
        px = floor_shr(c * 1048576 - a * s, 16);
        py = floor_shr(s * 1048576 + a * c, 16);
        rx = floor_shr(d * c - x * s, 16);
        ry = floor_shr(d * s + x * c, 16) + x0;
        num = px * ry - py * rx;
        cr = floor_shr(-px * a0 - py * 1048576, 20);
        z = 0;
        dz = 0;
        if (cr == 0)
            return 1'b0;
        z = num / cr;
        if (z < -64'sd2147483648)
            z = -64'sd2147483648;
        if (z > 64'sd2147483647)
            z = 64'sd2147483647;
        mag = (cr < 0) ? -cr : cr;
        dz = (d * g) / mag;
        return 1'b1;
    endfunction

    function automatic tvx_result_t predict_vertex(tvx_item_t ev);
        tvx_result_t r;
        longint zl, zr, dl, dr, m, wl, wr, vz, num;
        bit ok_l, ok_r;
        int k;
        r = '0;
        ok_l = arm_cross(longint'(arm_cfg.left_distance), longint'(arm_cfg.left_cos),
                         longint'(arm_cfg.left_sin), longint'(ev.left_position),
                         longint'(ev.left_slope), longint'(ev.left_slope_sigma),
                         longint'(ev.beam_x), longint'(ev.beam_slope_x), zl, dl);
        ok_r = arm_cross(longint'(arm_cfg.right_distance), longint'(arm_cfg.right_cos),
                         longint'(arm_cfg.right_sin), longint'(ev.right_position),
                         longint'(ev.right_slope), longint'(ev.right_slope_sigma),
                         longint'(ev.beam_x), longint'(ev.beam_slope_x), zr, dr);
        r.angle_x = 24'(sat24(-longint'(ev.beam_slope_x)));
        r.angle_y = ev.beam_slope_y;
        r.status  = 1'b1;
        if (ok_l && ok_r)
        begin
            m = (dl > dr) ? dl : dr;
            k = 0;
            while ((m >> k) >= 32768)
                k++;
            wl = (dl >> k) * (dl >> k);
            wr = (dr >> k) * (dr >> k);
            if (wl + wr != 0)
            begin
                num = zl * wr + zr * wl;
                vz = sat24(num / (wl + wr));
                r.vertex_z = 24'(vz);
                r.vertex_x = 24'(sat24(-longint'(ev.beam_x)
                                       - floor_shr(vz * longint'(ev.beam_slope_x), 20)));
                r.vertex_y = 24'(sat24(longint'(ev.beam_y)
                                       + floor_shr(vz * longint'(ev.beam_slope_y), 20)));
                r.status = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic send_event(tvx_item_t ev);
        send_q.push_back(ev);
        while (send_q.size() > 2)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_LEFT_DISTANCE:  arm_cfg.left_distance  = val;
            REG_RIGHT_DISTANCE: arm_cfg.right_distance = val;
            REG_LEFT_COS:       arm_cfg.left_cos       = val[TRIG_W-1:0];
            REG_LEFT_SIN:       arm_cfg.left_sin       = val[TRIG_W-1:0];
            REG_RIGHT_COS:      arm_cfg.right_cos      = val[TRIG_W-1:0];
            REG_RIGHT_SIN:      arm_cfg.right_sin      = val[TRIG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        while (send_q.size() != 0 || item_valid || vertex_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_arms(logic [23:0] dl, logic [23:0] dr, logic [17:0] cl,
                            logic [17:0] sl, logic [17:0] cr, logic [17:0] sr);
        drain_pipeline();
        write_reg(REG_LEFT_DISTANCE, dl);
        write_reg(REG_RIGHT_DISTANCE, dr);
        write_reg(REG_LEFT_COS, {{6{cl[17]}}, cl});
        write_reg(REG_LEFT_SIN, {{6{sl[17]}}, sl});
        write_reg(REG_RIGHT_COS, {{6{cr[17]}}, cr});
        write_reg(REG_RIGHT_SIN, {{6{sr[17]}}, sr});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rnd24(bit tame);
        logic [23:0] v;
        v = 24'($urandom);
        if (tame && $urandom_range(3) != 0)
            v = {{10{v[13]}}, v[13:0]};
        return v;
    endfunction

    function automatic tvx_item_t random_event();
        tvx_item_t ev;
        bit tame;
        tame = $urandom_range(3) != 0;
        ev.tracks_present    = $urandom_range(9) != 0;
        ev.left_position     = rnd24(tame);
        ev.left_slope        = rnd24(tame);
        ev.left_slope_sigma  = 23'(rnd24(tame));
        ev.right_position    = rnd24(tame);
        ev.right_slope       = rnd24(tame);
        ev.right_slope_sigma = 23'(rnd24(tame));
        ev.beam_x            = rnd24(tame);
        ev.beam_y            = rnd24(tame);
        ev.beam_slope_x      = rnd24(tame);
        ev.beam_slope_y      = rnd24(tame);
        return ev;
    endfunction

    // input side: offers queued events with random idling between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                n_events++;
                if (item.tracks_present)
                    vertex_q.push_back(predict_vertex(item));
            end
            if (!item_valid || item_ready)
            begin
                if (send_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= send_q.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result side: random stall, optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        tvx_result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            n_vertices++;
            if (result.status)
                n_status++;
            if (vertex_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                errors++;
            end
            else
            begin
                exp_r = vertex_q.pop_front();
                if (result !== exp_r)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        tvx_item_t ev;
        set_arms(24'd16000, 24'd16000, 18'sd46341, 18'sd46341, 18'sd46341, -18'sd46341);
        ev = '0;
        ev.tracks_present = 1'b1;
        ev.left_slope_sigma = 23'd1000;
        ev.right_slope_sigma = 23'd2000;
        send_event(ev);
        ev.tracks_present = 1'b0;
        send_event(ev);
        ev = '1;
        send_event(ev);
        ev = '0;
        ev.tracks_present = 1'b1;
        ev.left_position = 24'h7fffff;
        ev.right_position = 24'h800000;
        ev.left_slope = 24'h800000;
        ev.right_slope = 24'h7fffff;
        ev.left_slope_sigma = 23'h7fffff;
        ev.right_slope_sigma = 23'h7fffff;
        ev.beam_x = 24'h800000;
        ev.beam_y = 24'h7fffff;
        ev.beam_slope_x = 24'h800000;
        ev.beam_slope_y = 24'h800000;
        send_event(ev);
        ev.beam_x = 24'h7fffff;
        ev.beam_y = 24'h800000;
        ev.beam_slope_x = 24'h7fffff;
        ev.beam_slope_y = 24'h7fffff;
        send_event(ev);
        // zero weights: zero sigma on both arms
        ev = '0;
        ev.tracks_present = 1'b1;
        ev.left_position = 24'd500;
        ev.beam_slope_x = 24'd300000;
        send_event(ev);
        // left arm of unit slope against a beam slope of minus one, small sigma on both arms
        ev = '0;
        ev.tracks_present = 1'b1;
        ev.left_slope = 24'd1048576;
        ev.beam_slope_x = -24'sd1048576;
        ev.left_slope_sigma = 23'd10;
        ev.right_slope_sigma = 23'd10;
        send_event(ev);
        for (int i = 0; i < 10; i++)
            send_event(random_event());
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_event(random_event());
    endtask

    task automatic test_config_extremes();
        set_arms(24'hffffff, 24'h000000, 18'sh1ffff, 18'sh20000, 18'sh20000, 18'sh1ffff);
        test_random(120);
        set_arms(24'h000000, 24'hffffff, -18'sd65536, 18'sd0, 18'sd0, 18'sd65536);
        test_random(120);
        set_arms(24'($urandom), 24'($urandom), 18'($urandom), 18'($urandom),
                 18'($urandom), 18'($urandom));
        test_random(80);
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        test_random(150);
        idle_pct = 24;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(200);
        join
    endtask

    initial
    begin
        arm_cfg = '0;
        arm_cfg.left_cos  = COS_RESET;
        arm_cfg.right_cos = COS_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_random(20);
        test_directed();
        test_random(100);
        test_no_idle();
        test_backpressure();
        test_config_extremes();
        drain_pipeline();
        $display("%0d events sent, %0d vertices checked (%0d with zero divisor)",
                 n_events, n_vertices, n_status);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
